[design/apbu_pkg.sv]
// Shared types and constants for the ARGB pixel blend unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package apbu_pkg;

	// blend_mode codes
	localparam logic [2:0] MODE_TRANS        = 3'd0;
	localparam logic [2:0] MODE_ADD_ALPHA    = 3'd1;
	localparam logic [2:0] MODE_OPAQUE       = 3'd2;
	localparam logic [2:0] MODE_COLORIZE     = 3'd3;
	localparam logic [2:0] MODE_COLORIZE_LIT = 3'd4;

	// configuration register indexes
	localparam logic CFG_MODE   = 1'b0;
	localparam logic CFG_AMOUNT = 1'b1;

	localparam int NUM_W  = 24;   // colorize numerator
	localparam int DEN_W  = 16;   // colorize denominator
	localparam int QUO_W  = 9;    // quotient before saturation
	localparam int LVL_W  = 16;   // level in units of 1/250
	localparam int STEPS  = 3;    // quotient bits resolved per divider stage

	localparam logic [31:0] RB_MASK  = 32'h00FF00FF;
	localparam logic [31:0] G_MASK   = 32'h0000FF00;
	localparam logic [31:0] RGB_MASK = 32'h00FFFFFF;
	localparam logic [31:0] A_MASK   = 32'hFF000000;

	localparam logic [15:0] LIT_DIV  = 16'd250;
	localparam logic [16:0] LIT_BIAS = 17'd63750;  // 255 * 250
	localparam logic [7:0]  LIT_HALF = 8'd125;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} div_lane_t;

	typedef struct packed {
		div_lane_t [2:0]  lane;    // 2 red, 1 green, 0 blue
		logic [DEN_W-1:0] den;
		logic             use_div;
		logic [7:0]       alpha;
		logic [31:0]      plain;
	} div_word_t;

endpackage

`default_nettype wire

[design/apbu_if.sv]
// Stream interfaces of the ARGB pixel blend unit: pixel pair in, blended pixel out.
// No dependencies.
`default_nettype none

interface apbu_pix_if;
	logic        valid;
	logic        ready;
	logic [31:0] src_pixel;
	logic [31:0] dst_pixel;

	modport source (output valid, output src_pixel, output dst_pixel, input ready);
	modport sink   (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

interface apbu_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_pixel;

	modport source (output valid, output out_pixel, input ready);
	modport sink   (input valid, input out_pixel, output ready);
endinterface

`default_nettype wire

[design/argb_pixel_blend_unit.sv]
// ARGB pixel blend unit, top level: config registers, front end, divider, output pack.
// Pipeline: five register stages, stages 1-2 in apbu_front and stages 3-5 in apbu_divider.
// Throughput: one transaction per clock; stalls back up stage by stage, bubbles collapse.
// Reset: arst_n clears all stage valid bits and sets blend_mode and blend_amount to 0.
// Depends on apbu_pkg, apbu_if, apbu_front and apbu_divider.
`default_nettype none

module argb_pixel_blend_unit import apbu_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	apbu_pix_if.sink        pixels,
	apbu_res_if.source      blended,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_wdata
);

	// Configuration. Writes must only land while the pipe is empty; the user must keep to
	// this, the block does not enforce it. The mode and amount are sampled once, in stage 1, and travel no further.
	logic [2:0] blend_mode_q;
	logic [7:0] blend_amount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q   <= MODE_TRANS;
			blend_amount_q <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:   blend_mode_q   <= cfg_wdata[2:0];
				CFG_AMOUNT: blend_amount_q <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	// Stages 1-2: maxima, level, the non-colorize modes (finished here and
	// carried in .plain), and numerator sc*L + 125*vs per lane.
	logic      front_valid, front_ready;
	div_word_t front_word;

	apbu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixels   (pixels),
		.mode     (blend_mode_q),
		.amount   (blend_amount_q),
		.dn_valid (front_valid),
		.dn_ready (front_ready),
		.dn_word  (front_word)
	);

	// Stages 3-5: numerator / (250*vs), nine quotient bits, rounding folded
	// into the numerator so a plain floor gives round half up.
	logic      div_valid;
	div_word_t div_word;

	apbu_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (front_valid),
		.up_ready (front_ready),
		.up_word  (front_word),
		.dn_valid (div_valid),
		.dn_ready (blended.ready),
		.dn_word  (div_word)
	);

	// Quotient can reach 260 in lit mode with amount above 250: clip to 255.
	function automatic logic [7:0] sat8(input logic [QUO_W-1:0] q);
		return (q > QUO_W'(255)) ? 8'hFF : q[7:0];
	endfunction

	assign blended.valid     = div_valid;
	assign blended.out_pixel = div_word.use_div
	                         ? {div_word.alpha, sat8(div_word.lane[2].quo),
	                            sat8(div_word.lane[1].quo), sat8(div_word.lane[0].quo)}
	                         : div_word.plain;

`ifndef SYNTHESIS
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		front_valid && !front_ready |=> front_valid && $stable(front_word))
		else $error("front stage lost or changed a stalled transaction");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		front_valid && front_word.use_div |-> front_word.den != '0)
		else $error("colorize denominator is zero");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid && div_word.use_div |->
			(div_word.lane[0].rem < NUM_W'(div_word.den)) &&
			(div_word.lane[1].rem < NUM_W'(div_word.den)) &&
			(div_word.lane[2].rem < NUM_W'(div_word.den)))
		else $error("divider remainder not reduced below denominator");

	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid && div_word.use_div |->
			(div_word.lane[0].quo <= QUO_W'(260)) &&
			(div_word.lane[1].quo <= QUO_W'(260)) &&
			(div_word.lane[2].quo <= QUO_W'(260)))
		else $error("colorize quotient out of range");
`endif

endmodule

`default_nettype wire

[design/apbu_front.sv]
// Front end, stages 1 and 2: channel maxima, level, plain modes, colorize numerators.
// Depends on apbu_pkg and apbu_if.
`default_nettype none

module apbu_front import apbu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	apbu_pix_if.sink         pixels,
	input  wire logic [2:0]  mode,
	input  wire logic [7:0]  amount,
	output logic             dn_valid,
	input  wire logic        dn_ready,
	output div_word_t        dn_word
);

	function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
	                                    input logic [7:0] c);
		logic [7:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	logic [31:0] s, d, dl;
	logic [7:0]  vs, vd, vs_eff;
	logic [7:0]  sc [3];
	logic [7:0]  sc_eff [3];
	logic [16:0] lit_sum;
	logic [LVL_W-1:0] lvl;
	logic [8:0]  n;
	logic [31:0] rb_prod, g_prod, mix;
	logic [8:0]  asum;
	logic [7:0]  asat;
	logic [31:0] plain;

	assign s  = pixels.src_pixel;
	assign d  = pixels.dst_pixel;
	assign dl = d & RGB_MASK;
	assign sc[2] = s[23:16];
	assign sc[1] = s[15:8];
	assign sc[0] = s[7:0];
	assign vs = max3(s[23:16], s[15:8], s[7:0]);
	assign vd = max3(d[23:16], d[15:8], d[7:0]);

	// black source: unit numerator and denominator give round(level / 250)
	assign vs_eff = (vs == 8'd0) ? 8'd1 : vs;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sc_eff[i] = (vs == 8'd0) ? 8'd1 : sc[i];
		end
	end

	// lit level: vd*250 - 255*(250 - amount), floored at 0
	assign lit_sum = {9'b0, vd} * 17'd250 + {9'b0, amount} * 17'd255;
	always_comb begin
		if (mode == MODE_COLORIZE_LIT) begin
			lvl = (lit_sum >= LIT_BIAS) ? LVL_W'(lit_sum - LIT_BIAS) : '0;
		end else begin
			lvl = LVL_W'({8'b0, vd} * LIT_DIV);
		end
	end

	// translucent mix in wrapping 32-bit lane arithmetic
	assign n       = (amount == 8'd0) ? 9'd0 : {1'b0, amount} + 9'd1;
	assign rb_prod = ((s & RB_MASK) - (dl & RB_MASK)) * {23'b0, n};
	assign g_prod  = ((s & G_MASK) - (dl & G_MASK)) * {23'b0, n};
	assign mix     = ((((rb_prod >> 8) + dl) & RB_MASK)
	                | (((g_prod >> 8) + (dl & G_MASK)) & G_MASK)
	                | (d & A_MASK));

	assign asum = {1'b0, s[31:24]} + {1'b0, d[31:24]};
	assign asat = asum[8] ? 8'hFF : asum[7:0];

	always_comb begin
		unique case (mode)
			MODE_TRANS:     plain = mix;
			MODE_ADD_ALPHA: plain = {asat, s[23:0]};
			MODE_OPAQUE:    plain = s | A_MASK;
			default:        plain = d;
		endcase
	end

	// stage 1 registers
	logic             v_s1;
	logic [7:0]       vs_s1;
	logic [7:0]       sc_s1 [3];
	logic [LVL_W-1:0] lvl_s1;
	logic [DEN_W-1:0] den_s1;
	logic             use_div_s1;
	logic [7:0]       alpha_s1;
	logic [31:0]      plain_s1;

	// stage 2 registers
	logic      v_s2;
	div_word_t word_s2;

	logic en1, en2;
	assign en2 = !v_s2 || dn_ready;
	assign en1 = !v_s1 || en2;
	assign pixels.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pixels.valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && pixels.valid) begin
			vs_s1      <= vs_eff;
			sc_s1      <= sc_eff;
			lvl_s1     <= lvl;
			den_s1     <= DEN_W'({8'b0, vs_eff} * LIT_DIV);
			use_div_s1 <= (mode == MODE_COLORIZE) || (mode == MODE_COLORIZE_LIT);
			alpha_s1   <= d[31:24];
			plain_s1   <= plain;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			for (int i = 0; i < 3; i++) begin
				word_s2.lane[i].rem <= {16'b0, sc_s1[i]} * {8'b0, lvl_s1}
				                     + {16'b0, vs_s1} * {16'b0, LIT_HALF};
				word_s2.lane[i].quo <= '0;
			end
			word_s2.den     <= den_s1;
			word_s2.use_div <= use_div_s1;
			word_s2.alpha   <= alpha_s1;
			word_s2.plain   <= plain_s1;
		end
	end

	assign dn_valid = v_s2;
	assign dn_word  = word_s2;

endmodule

`default_nettype wire

[design/apbu_divider.sv]
// Restoring divider, stages 3 to 5: three quotient bits per stage on all three lanes.
// Depends on apbu_pkg.
`default_nettype none

module apbu_divider import apbu_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  up_valid,
	output logic       up_ready,
	input  wire div_word_t up_word,
	output logic       dn_valid,
	input  wire logic  dn_ready,
	output div_word_t  dn_word
);

	localparam int TOP3 = QUO_W - 1;
	localparam int TOP4 = QUO_W - 1 - STEPS;
	localparam int TOP5 = QUO_W - 1 - 2 * STEPS;

	// STEPS restoring steps, quotient bits top down to top-STEPS+1
	function automatic div_word_t div_stage(input div_word_t w, input int top);
		div_word_t          r;
		logic [NUM_W:0]     dsh;
		logic [NUM_W:0]     rx;
		r = w;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < STEPS; j++) begin
				dsh = (NUM_W+1)'(w.den) << (top - j);
				rx  = {1'b0, r.lane[i].rem};
				if (rx >= dsh) begin
					r.lane[i].rem = NUM_W'(rx - dsh);
					r.lane[i].quo[top - j] = 1'b1;
				end
			end
		end
		return r;
	endfunction

	logic      v_s3, v_s4, v_s5;
	div_word_t word_s3, word_s4, word_s5;
	logic      en3, en4, en5;

	assign en5 = !v_s5 || dn_ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign up_ready = en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en3) v_s3 <= up_valid;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && up_valid) word_s3 <= div_stage(up_word, TOP3);
		if (en4 && v_s3)     word_s4 <= div_stage(word_s3, TOP4);
		if (en5 && v_s4)     word_s5 <= div_stage(word_s4, TOP5);
	end

	assign dn_valid = v_s5;
	assign dn_word  = word_s5;

endmodule

`default_nettype wire
